/* rtl/core/lcdt_pkg.sv */
// shared types and constants for the lcd mode and line timing block
package lcdt_pkg;

  localparam int unsigned CYC_W  = 8;
  localparam int unsigned LINE_W = 8;
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned CFG_W  = 8;
  localparam int unsigned IDX_W  = 2;
  // signed width of the countdown after subtraction
  localparam int unsigned DIFF_W = 12;

  localparam logic [CNT_W-1:0]  LINE_CYCLES   = 10'd456;
  localparam logic [DIFF_W-1:0] SEARCH_LIMIT  = 12'd379;  // 456 - 77
  localparam logic [DIFF_W-1:0] XFER_LIMIT    = 12'd287;  // 456 - 169
  localparam logic [LINE_W-1:0] VBLANK_LINE   = 8'd144;
  localparam logic [LINE_W-1:0] LAST_LINE     = 8'd153;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  localparam logic [IDX_W-1:0] REG_DISPLAY_ENABLE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_STAT_INT_ENABLE = 2'd1;
  localparam logic [IDX_W-1:0] REG_COMPARE_LINE    = 2'd2;

  // stat_int_enable bit positions
  localparam int unsigned IE_MODE0 = 0;
  localparam int unsigned IE_MODE1 = 1;
  localparam int unsigned IE_MODE2 = 2;
  localparam int unsigned IE_MATCH = 3;

  typedef struct packed {
    logic              display_enable;
    logic [3:0]        stat_int_enable;
    logic [LINE_W-1:0] compare_line;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  countdown;
    mode_t             mode;
    logic [LINE_W-1:0] line;
    logic              match_flag;
  } state_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [LINE_W-1:0] line;
    logic              coincidence;
    logic              stat_irq;
    logic              vblank_irq;
    logic              draw_valid;
    logic [LINE_W-1:0] draw_line_index;
  } result_t;

endpackage

/* rtl/core/lcdt_in_if.sv */
// tick item channel: elapsed cycle count
interface lcdt_in_if;
  logic                     valid;
  logic                     ready;
  logic [lcdt_pkg::CYC_W-1:0] cycles;

  modport source (output valid, output cycles, input ready);
  modport sink   (input valid, input cycles, output ready);
endinterface

/* rtl/core/lcdt_out_if.sv */
// result item channel: mode, line, flags and draw request
interface lcdt_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [lcdt_pkg::LINE_W-1:0] line;
  logic                        coincidence;
  logic                        stat_irq;
  logic                        vblank_irq;
  logic                        draw_valid;
  logic [lcdt_pkg::LINE_W-1:0] draw_line_index;

  modport source (output valid, output mode, output line, output coincidence,
                  output stat_irq, output vblank_irq, output draw_valid,
                  output draw_line_index, input ready);
  modport sink   (input valid, input mode, input line, input coincidence,
                  input stat_irq, input vblank_irq, input draw_valid,
                  input draw_line_index, output ready);
endinterface

/* rtl/core/lcd_mode_line_timing_top.sv */
// top level: tick item input register, timing state update, result register
//
// Each accepted tick item advances the scanline timer by its cycle count and
// yields one result item. The block takes one item per clock while the result
// side accepts; a stalled result holds the item in the input register. An
// accepted item is loaded into the input register, then the state update runs
// and loads the result register, which makes the result valid. The countdown,
// mode and line registers are read and written by each item in turn.
// Configuration writes take effect for items that reach the update stage
// after the write.
module lcd_mode_line_timing_top (
  input  logic                        clk,
  input  logic                        rst_n,
  lcdt_in_if.sink                     in_ch,
  lcdt_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [lcdt_pkg::IDX_W-1:0]  cfg_index,
  input  logic [lcdt_pkg::CFG_W-1:0]  cfg_data
);
  import lcdt_pkg::*;

  cfg_t    cfg;
  state_t  state_r, state_nxt;
  result_t res_r, res_nxt;

  logic             in_valid_r;
  logic [CYC_W-1:0] cycles_r;
  logic             out_valid_r;
  logic             advance;
  logic             fire;

  lcdt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lcdt_step u_step (
    .cfg       (cfg),
    .state     (state_r),
    .cycles    (cycles_r),
    .state_nxt (state_nxt),
    .res       (res_nxt)
  );

  assign advance      = !out_valid_r || out_ch.ready;
  assign fire         = in_valid_r && advance;
  assign in_ch.ready  = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{countdown: LINE_CYCLES, mode: MODE_HBLANK,
                       line: '0, match_flag: 1'b0};
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cycles_r <= in_ch.cycles;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.mode            = res_r.mode;
  assign out_ch.line            = res_r.line;
  assign out_ch.coincidence     = res_r.coincidence;
  assign out_ch.stat_irq        = res_r.stat_irq;
  assign out_ch.vblank_irq      = res_r.vblank_irq;
  assign out_ch.draw_valid      = res_r.draw_valid;
  assign out_ch.draw_line_index = res_r.draw_line_index;

  // a pending tick item waits in the input register until the update runs
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(cycles_r)))
    else $error("pending tick item lost or changed");

  // a disabled display leaves line 0 and a full countdown
  a_disabled_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !cfg.display_enable) |=>
      (state_r.line == '0 && state_r.countdown == LINE_CYCLES))
    else $error("disabled step did not reload timing state");

  // countdown and line stay in their ranges between items
  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.countdown != '0 && state_r.countdown <= LINE_CYCLES
     && state_r.line <= LAST_LINE + 8'd1))
    else $error("timing state out of range");

  // a result never carries both a draw request and a vblank interrupt
  a_draw_vblank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.draw_valid && res_r.vblank_irq))
    else $error("draw and vblank requested together");
endmodule

/* rtl/core/lcdt_cfg_regs.sv */
// configuration register file with plain write port
module lcdt_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lcdt_pkg::IDX_W-1:0]  cfg_index,
  input  logic [lcdt_pkg::CFG_W-1:0]  cfg_data,
  output lcdt_pkg::cfg_t              cfg
);
  import lcdt_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DISPLAY_ENABLE:  cfg_nxt.display_enable  = cfg_data[0];
        REG_STAT_INT_ENABLE: cfg_nxt.stat_int_enable = cfg_data[3:0];
        REG_COMPARE_LINE:    cfg_nxt.compare_line    = cfg_data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

/* rtl/core/lcdt_step.sv */
// next state and result for one tick item
module lcdt_step (
  input  lcdt_pkg::cfg_t              cfg,
  input  lcdt_pkg::state_t            state,
  input  logic [lcdt_pkg::CYC_W-1:0]  cycles,
  output lcdt_pkg::state_t            state_nxt,
  output lcdt_pkg::result_t           res
);
  import lcdt_pkg::*;

  logic signed [DIFF_W-1:0] cnt;
  logic                     expired;
  logic                     in_vblank;
  logic                     match;
  mode_t                    new_mode;
  logic                     mode_irq;

  always_comb begin
    cnt = $signed({{(DIFF_W-CNT_W){1'b0}}, state.countdown})
        - $signed({{(DIFF_W-CYC_W){1'b0}}, cycles});
    expired   = (cnt <= $signed({DIFF_W{1'b0}}));
    in_vblank = (state.line >= VBLANK_LINE);
    match     = (state.line == cfg.compare_line);

    if (in_vblank) begin
      new_mode = MODE_VBLANK;
      mode_irq = cfg.stat_int_enable[IE_MODE1];
    end else if (cnt > $signed(SEARCH_LIMIT)) begin
      new_mode = MODE_SEARCH;
      mode_irq = cfg.stat_int_enable[IE_MODE2];
    end else if (cnt > $signed(XFER_LIMIT)) begin
      new_mode = MODE_XFER;
      mode_irq = 1'b0;
    end else begin
      new_mode = MODE_HBLANK;
      mode_irq = cfg.stat_int_enable[IE_MODE0];
    end

    state_nxt = state;
    res       = '0;
    if (!cfg.display_enable) begin
      state_nxt.mode      = MODE_VBLANK;
      state_nxt.countdown = LINE_CYCLES;
      state_nxt.line      = '0;
      res.mode            = MODE_VBLANK;
      res.coincidence     = state.match_flag;
    end else begin
      state_nxt.mode       = new_mode;
      state_nxt.match_flag = match;
      if (expired) begin
        state_nxt.countdown = LINE_CYCLES;
        state_nxt.line      = (state.line > LAST_LINE) ? '0 : state.line + 1'b1;
      end else begin
        state_nxt.countdown = cnt[CNT_W-1:0];
      end
      res.mode            = new_mode;
      res.line            = state_nxt.line;
      res.coincidence     = match;
      res.stat_irq        = (mode_irq && (new_mode != state.mode))
                          || (match && cfg.stat_int_enable[IE_MATCH]);
      res.vblank_irq      = expired && (state.line == VBLANK_LINE);
      res.draw_valid      = expired && !in_vblank;
      res.draw_line_index = (expired && !in_vblank) ? state.line : '0;
    end
  end
endmodule

/* bench/lcdt_bench_pkg.sv */
`timescale 1ns / 1ps
// scoreboard for the lcd timing bench: scanline timer prediction and result checks
package lcdt_bench_pkg;
  import lcdt_pkg::*;

  class timing_scoreboard;
    cfg_t              regs;
    logic [CNT_W-1:0]  countdown;
    mode_t             cur_mode;
    logic [LINE_W-1:0] cur_line;
    logic              match_flag;
    result_t           expected_q[$];

    int unsigned errors, ticks, results, draws, vblanks, stat_irqs, wraps, max_line;
    logic [3:0]  modes_seen;

    function new();
      regs       = '0;
      countdown  = LINE_CYCLES;
      cur_mode   = MODE_HBLANK;
      cur_line   = '0;
      match_flag = 1'b0;
      errors     = 0;
      ticks      = 0;
      results    = 0;
      draws      = 0;
      vblanks    = 0;
      stat_irqs  = 0;
      wraps      = 0;
      max_line   = 0;
      modes_seen = '0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_DISPLAY_ENABLE:  regs.display_enable  = data[0];
        REG_STAT_INT_ENABLE: regs.stat_int_enable = data[3:0];
        REG_COMPARE_LINE:    regs.compare_line    = data;
        default: ;
      endcase
    endfunction

    // advance the line timer by one tick item and queue the result it must give
    function void note_tick(logic [CYC_W-1:0] cycles);
      result_t           want;
      int                left;
      logic [LINE_W-1:0] prev;
      mode_t             next_mode;
      want = '0;
      ticks++;
      if (!regs.display_enable) begin
        cur_mode  = MODE_VBLANK;
        countdown = LINE_CYCLES;
        cur_line  = '0;
      end else begin
        left = int'(countdown) - int'(cycles);
        prev = cur_line;
        if (prev >= VBLANK_LINE) begin
          next_mode = MODE_VBLANK;
          want.stat_irq = (cur_mode != MODE_VBLANK) && regs.stat_int_enable[IE_MODE1];
        end else if (left > int'(SEARCH_LIMIT)) begin
          next_mode = MODE_SEARCH;
          want.stat_irq = (cur_mode != MODE_SEARCH) && regs.stat_int_enable[IE_MODE2];
        end else if (left > int'(XFER_LIMIT)) begin
          // transfer never interrupts
          next_mode = MODE_XFER;
        end else begin
          next_mode = MODE_HBLANK;
          want.stat_irq = (cur_mode != MODE_HBLANK) && regs.stat_int_enable[IE_MODE0];
        end
        cur_mode = next_mode;

        if (left <= 0) begin
          if (prev < VBLANK_LINE) begin
            want.draw_valid      = 1'b1;
            want.draw_line_index = prev;
          end else if (prev == VBLANK_LINE) begin
            want.vblank_irq = 1'b1;
          end
          if (prev > LAST_LINE) begin
            cur_line = '0;
            wraps++;
          end else begin
            cur_line = prev + 1'b1;
          end
          left = int'(LINE_CYCLES);
        end
        countdown = CNT_W'(left);

        // level behavior: every matching step raises it again
        match_flag = (prev == regs.compare_line);
        if (match_flag && regs.stat_int_enable[IE_MATCH]) want.stat_irq = 1'b1;
      end

      want.mode        = cur_mode;
      want.line        = cur_line;
      want.coincidence = match_flag;
      draws     += want.draw_valid;
      vblanks   += want.vblank_irq;
      stat_irqs += want.stat_irq;
      modes_seen[cur_mode] = 1'b1;
      if (cur_line > max_line) max_line = cur_line;
      expected_q.push_back(want);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      if (errors <= 40)
        $display("mismatch at result %0d: %s is %0d, expected %0d", results, what, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      results++;
      if (expected_q.size() == 0) begin
        report("unexpected result, line", got.line, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.mode != want.mode) report("mode", got.mode, want.mode);
        if (got.line != want.line) report("line", got.line, want.line);
        if (got.coincidence != want.coincidence)
          report("coincidence", got.coincidence, want.coincidence);
        if (got.stat_irq != want.stat_irq) report("stat_irq", got.stat_irq, want.stat_irq);
        if (got.vblank_irq != want.vblank_irq)
          report("vblank_irq", got.vblank_irq, want.vblank_irq);
        if (got.draw_valid != want.draw_valid)
          report("draw_valid", got.draw_valid, want.draw_valid);
        if (got.draw_line_index != want.draw_line_index)
          report("draw_line_index", got.draw_line_index, want.draw_line_index);
      end
    endtask
  endclass

endpackage

/* bench/lcd_mode_line_timing_top_tb.sv */
`timescale 1ns / 1ps
// testbench for lcd_mode_line_timing_top: random tick items checked against a timer model
module lcd_mode_line_timing_top_tb;
  import lcdt_pkg::*;
  import lcdt_bench_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 90;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  bit               steady;
  bit               hold_off_req;
  int unsigned      quiet;
  timing_scoreboard sb;

  lcdt_in_if  in_ch();
  lcdt_out_if out_ch();

  lcd_mode_line_timing_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 17);
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t got;
    if (!rst_n) begin
      quiet = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.mode            = out_ch.mode;
        got.line            = out_ch.line;
        got.coincidence     = out_ch.coincidence;
        got.stat_irq        = out_ch.stat_irq;
        got.vblank_irq      = out_ch.vblank_irq;
        got.draw_valid      = out_ch.draw_valid;
        got.draw_line_index = out_ch.draw_line_index;
        sb.check_result(got);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_tick(input logic [CYC_W-1:0] cycles);
    // idle cycles, each one drawn on its own
    while (!steady && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.cycles <= cycles;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_tick(cycles);
  endtask

  // every queued result back, then let the pipeline settle
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic load_regs(input logic de, input logic [3:0] ie, input logic [7:0] cmp);
    write_reg(REG_DISPLAY_ENABLE, {7'd0, de});
    write_reg(REG_STAT_INT_ENABLE, {4'd0, ie});
    write_reg(REG_COMPARE_LINE, cmp);
    cfg_we <= 1'b0;
  endtask

  // mostly long ticks so lines advance quickly, some short ones to land in each window
  function automatic logic [CYC_W-1:0] pick_cycles();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return CYC_W'($urandom_range(255, 150));
    else if (r < 85) return CYC_W'($urandom_range(80, 0));
    else return CYC_W'($urandom_range(255, 0));
  endfunction

  task automatic run_phase(input int unsigned count, input bit hold_mid, input bit pause_mid);
    for (int unsigned i = 0; i < count; i++) begin
      if (hold_mid && i == count / 3) hold_off_req = 1'b1;
      if (pause_mid && i == count / 2) begin
        in_ch.valid <= 1'b0;
        drain();
      end
      send_tick(pick_cycles());
    end
    in_ch.valid <= 1'b0;
    drain();
  endtask

  initial begin : stimulus
    logic [CYC_W-1:0] walk [13] = '{8'd1, 8'd76, 8'd92, 8'd255, 8'd32, 8'd0, 8'd255,
                                    8'd201, 8'd128, 8'd200, 8'd255, 8'd77, 8'd169};
    sb = new();
    in_ch.valid  = 1'b0;
    in_ch.cycles = '0;
    steady       = 1'b0;
    hold_off_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // display off after reset: held in vblank on line 0
    send_tick(8'hFF);
    send_tick(8'h00);
    send_tick(8'hAA);
    send_tick(8'h55);
    in_ch.valid <= 1'b0;
    drain();

    // walk through search, transfer and hblank windows and three line ends
    load_regs(1'b1, 4'hF, 8'd0);
    foreach (walk[i]) send_tick(walk[i]);
    in_ch.valid <= 1'b0;
    drain();

    steady = 1'b1;
    load_regs(1'b1, 4'hF, 8'($urandom_range(154, 0)));
    run_phase(150, 1'b0, 1'b0);
    steady = 1'b0;
    load_regs(1'b1, 4'h0, 8'd255);
    run_phase(120, 1'b0, 1'b0);
    load_regs(1'b1, 4'($urandom_range(15, 0)), VBLANK_LINE);
    run_phase(120, 1'b1, 1'b0);
    load_regs(1'b1, 4'($urandom_range(15, 0)), LAST_LINE);
    run_phase(150, 1'b0, 1'b1);
    load_regs(1'b1, 4'hF, 8'd154);
    run_phase(120, 1'b0, 1'b0);
    load_regs(1'b0, 4'hF, 8'($urandom_range(255, 0)));
    run_phase(30, 1'b0, 1'b0);
    load_regs(1'b1, 4'($urandom_range(15, 0)), 8'($urandom_range(255, 0)));
    run_phase(100, 1'b0, 1'b0);

    repeat (8) @(posedge clk);
    $display("covered %0d tick items, %0d results: %0d line draws, %0d vblank irqs, %0d stat irqs",
             sb.ticks, sb.results, sb.draws, sb.vblanks, sb.stat_irqs);
    $display("modes seen %b, highest line %0d, %0d frame wraps, %0d mismatches",
             sb.modes_seen, sb.max_line, sb.wraps, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/lcdt_pkg.sv
rtl/core/lcdt_in_if.sv
rtl/core/lcdt_out_if.sv
rtl/core/lcdt_cfg_regs.sv
rtl/core/lcdt_step.sv
rtl/core/lcd_mode_line_timing_top.sv
bench/lcdt_bench_pkg.sv
bench/lcd_mode_line_timing_top_tb.sv
